// ===== hw/rtl/smtlb_pkg.sv =====
// Shared types, codes and field helpers for the software-managed TLB unit.
package smtlb_pkg;

	// Default number of TLB slots.
	localparam int ENTRY_COUNT_DEF = 16;

	// Width of the Index, EntryHi, EntryLo and PageMask words.
	localparam int WORD_W = 32;

	// Index reduction works on one hex digit of the Index word per cycle.
	localparam int RED_DIGIT_W = 4;
	localparam int RED_STEPS   = WORD_W / RED_DIGIT_W;
	localparam int RED_CNT_W   = $clog2(RED_STEPS);

	// Field positions in the EntryHi word.
	localparam int VPN2_LSB = 13;
	localparam int VPN2_W   = WORD_W - VPN2_LSB;
	localparam int ASID_W   = 8;

	// Field widths in the EntryLo word.
	localparam int PFN_W   = 26;
	localparam int CACHE_W = 3;

	// Bit set in Index when a probe finds nothing.
	localparam logic [WORD_W-1:0] MISS_BIT = 32'h8000_0000;

	// TLB instruction codes.
	typedef enum logic [1:0] {
		OP_WRITE_INDEXED = 2'd0,
		OP_WRITE_RANDOM  = 2'd1,
		OP_PROBE         = 2'd2,
		OP_READ          = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_WRITE,
		ST_RD_ISSUE,
		ST_PROBE,
		ST_FINISH
	} state_t;

	// Stored tag: VPN2, ASID and global bit.
	typedef struct packed {
		logic [VPN2_W-1:0] vpn2;
		logic [ASID_W-1:0] asid;
		logic              g;
	} tag_t;

	// Stored half of an entry: PFN, cache attribute, dirty and valid.
	typedef struct packed {
		logic [PFN_W-1:0]   pfn;
		logic [CACHE_W-1:0] c;
		logic               d;
		logic               v;
	} page_t;

	// One complete TLB entry as held in the store.
	typedef struct packed {
		tag_t              tag;
		logic [WORD_W-1:0] mask;
		page_t             even;
		page_t             odd;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic red_step;
		logic wr_en;
		logic rd_issue;
		logic probe_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic red_last;
		logic probe_done;
		logic out_free;
	} status_t;

	// Split an EntryLo word into the stored page fields.
	function automatic page_t pack_page(input logic [WORD_W-1:0] lo);
		page_t p;
		p.v   = lo[1];
		p.d   = lo[2];
		p.c   = lo[5:3];
		p.pfn = lo[31:6];
		return p;
	endfunction

	// Rebuild an EntryLo word from the stored page fields and the global bit.
	function automatic logic [WORD_W-1:0] unpack_page(input page_t p, input logic g);
		return {p.pfn, p.c, p.d, p.v, g};
	endfunction

endpackage

// ===== hw/rtl/smtlb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module smtlb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/smtlb_ctrl.sv =====
// Controller state machine that sequences each TLB instruction.
module smtlb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          opcode,
	input  smtlb_pkg::status_t  sts,
	output logic                in_stall,
	output smtlb_pkg::cmd_t     cmd
);

	smtlb_pkg::state_t state_q;
	smtlb_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smtlb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smtlb_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (smtlb_pkg::op_t'(opcode) == smtlb_pkg::OP_PROBE) begin
						state_d = smtlb_pkg::ST_PROBE;
					end else begin
						state_d = smtlb_pkg::ST_REDUCE;
					end
				end
			end
			smtlb_pkg::ST_REDUCE: begin
				if (sts.red_last) begin
					if (sts.op == smtlb_pkg::OP_READ) begin
						state_d = smtlb_pkg::ST_RD_ISSUE;
					end else begin
						state_d = smtlb_pkg::ST_WRITE;
					end
				end
			end
			smtlb_pkg::ST_WRITE: begin
				state_d = smtlb_pkg::ST_IDLE;
			end
			smtlb_pkg::ST_RD_ISSUE: begin
				state_d = smtlb_pkg::ST_FINISH;
			end
			smtlb_pkg::ST_PROBE: begin
				if (sts.probe_done) begin
					state_d = smtlb_pkg::ST_FINISH;
				end
			end
			smtlb_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					state_d = smtlb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smtlb_pkg::ST_IDLE;
			end
		endcase
	end

	// Commands for the datapath.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			smtlb_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			smtlb_pkg::ST_REDUCE: begin
				cmd.red_step = 1'b1;
			end
			smtlb_pkg::ST_WRITE: begin
				cmd.wr_en = 1'b1;
			end
			smtlb_pkg::ST_RD_ISSUE: begin
				cmd.rd_issue = 1'b1;
			end
			smtlb_pkg::ST_PROBE: begin
				cmd.probe_step = 1'b1;
			end
			smtlb_pkg::ST_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/smtlb_dp.sv =====
// Datapath: entry store, slot reduction, probe scan and output word register.
module smtlb_dp #(
	parameter int ENTRY_COUNT = smtlb_pkg::ENTRY_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smtlb_pkg::cmd_t     cmd,
	output smtlb_pkg::status_t  sts,
	input  logic [1:0]          opcode,
	input  logic [31:0]         entry_hi,
	input  logic [31:0]         entry_lo_even,
	input  logic [31:0]         entry_lo_odd,
	input  logic [31:0]         page_mask_in,
	input  logic [31:0]         index_in,
	input  logic [3:0]          random_slot,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [31:0]         index_out,
	output logic                probe_miss,
	output logic [31:0]         entry_hi_out,
	output logic [31:0]         entry_lo_even_out,
	output logic [31:0]         entry_lo_odd_out,
	output logic [31:0]         page_mask_out
);

	localparam int IW = $clog2(ENTRY_COUNT);
	localparam int TW = IW + 1;
	localparam int EW = $bits(smtlb_pkg::entry_t);
	localparam int DW = smtlb_pkg::RED_DIGIT_W;
	localparam int WW = smtlb_pkg::WORD_W;

	// Captured instruction.
	smtlb_pkg::op_t                   op_q;
	smtlb_pkg::entry_t                new_entry_q;
	logic [WW-1:0]                    idx_q;

	// Slot reduction.
	logic [smtlb_pkg::RED_CNT_W-1:0]  red_cnt_q;
	logic [IW-1:0]                    rem_q;
	logic [IW-1:0]                    rem_d;

	// Probe scan.
	logic [IW-1:0]                    scan_q;
	logic                             issue_done_q;
	logic                             chk_vld_s1;
	logic [IW-1:0]                    chk_slot_s1;
	logic                             chk_match;
	logic                             hit_q;
	logic [IW-1:0]                    hit_slot_q;

	// Store access.
	logic [ENTRY_COUNT-1:0]           valid_q;
	logic                             valid_s1;
	logic                             rd_en;
	logic [IW-1:0]                    rd_addr;
	logic [EW-1:0]                    rd_data;
	smtlb_pkg::entry_t                rd_entry;

	logic                             out_valid_q;
	logic                             out_free;

	// Capture the instruction and pack the entry to be written.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q                   <= smtlb_pkg::op_t'(opcode);
			new_entry_q.tag.vpn2   <= entry_hi[WW-1:smtlb_pkg::VPN2_LSB];
			new_entry_q.tag.asid   <= entry_hi[smtlb_pkg::ASID_W-1:0];
			new_entry_q.tag.g      <= entry_lo_even[0] & entry_lo_odd[0];
			new_entry_q.mask       <= page_mask_in;
			new_entry_q.even       <= smtlb_pkg::pack_page(entry_lo_even);
			new_entry_q.odd        <= smtlb_pkg::pack_page(entry_lo_odd);
		end
	end

	// One reduction step folds one hex digit into the running remainder.
	always_comb begin
		logic [TW-1:0] t;
		logic [IW-1:0] r;
		r = rem_q;
		for (int k = DW - 1; k >= 0; k--) begin
			t = {r, idx_q[WW-DW+k]};
			if (t >= TW'(ENTRY_COUNT)) begin
				t = t - TW'(ENTRY_COUNT);
			end
			r = t[IW-1:0];
		end
		rem_d = r;
	end

	// Index word shifts out a digit per step; a probe keeps it whole.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (smtlb_pkg::op_t'(opcode) == smtlb_pkg::OP_WRITE_RANDOM) begin
				idx_q <= WW'(random_slot);
			end else begin
				idx_q <= index_in;
			end
			rem_q <= '0;
		end else if (cmd.red_step) begin
			idx_q <= {idx_q[WW-DW-1:0], {DW{1'b0}}};
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_cnt_q <= '0;
		end else if (cmd.capture) begin
			red_cnt_q <= '0;
		end else if (cmd.red_step) begin
			red_cnt_q <= red_cnt_q + 1'b1;
		end
	end

	// Store read address: the scan slot during a probe, the reduced slot otherwise.
	assign rd_en   = cmd.rd_issue || (cmd.probe_step && !issue_done_q);
	assign rd_addr = cmd.probe_step ? scan_q : rem_q;

	smtlb_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRY_COUNT)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (rem_q),
		.wr_data (new_entry_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Per-slot written flags; an unwritten slot reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				valid_q[rem_q] <= 1'b1;
			end
			if (rd_en) begin
				valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_entry = valid_s1 ? smtlb_pkg::entry_t'(rd_data) : '0;

	// Compare the entry read in the previous cycle against the probe tag.
	assign chk_match = chk_vld_s1
		&& (rd_entry.tag.vpn2 == new_entry_q.tag.vpn2)
		&& (rd_entry.tag.g || (rd_entry.tag.asid == new_entry_q.tag.asid));

	// Probe scan: issue one slot a cycle and check it in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			chk_slot_s1  <= '0;
			hit_q        <= 1'b0;
			hit_slot_q   <= '0;
		end else if (cmd.capture) begin
			scan_q       <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
		end else if (cmd.probe_step) begin
			chk_vld_s1  <= !issue_done_q;
			chk_slot_s1 <= scan_q;
			if (!issue_done_q) begin
				if (scan_q == IW'(ENTRY_COUNT - 1)) begin
					issue_done_q <= 1'b1;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (sts.probe_done) begin
				hit_q      <= chk_match;
				hit_slot_q <= chk_slot_s1;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Status for the controller.
	always_comb begin
		sts.op         = op_q;
		sts.red_last   = red_cnt_q == smtlb_pkg::RED_CNT_W'(smtlb_pkg::RED_STEPS - 1);
		sts.probe_done = chk_match || (chk_vld_s1 && chk_slot_s1 == IW'(ENTRY_COUNT - 1));
		sts.out_free   = out_free;
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output word payload, built from the probe result or the entry read.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (op_q == smtlb_pkg::OP_PROBE) begin
				index_out         <= hit_q ? WW'(hit_slot_q) : (idx_q | smtlb_pkg::MISS_BIT);
				probe_miss        <= !hit_q;
				entry_hi_out      <= '0;
				entry_lo_even_out <= '0;
				entry_lo_odd_out  <= '0;
				page_mask_out     <= '0;
			end else begin
				index_out         <= '0;
				probe_miss        <= 1'b0;
				entry_hi_out      <= {rd_entry.tag.vpn2,
					{(smtlb_pkg::VPN2_LSB - smtlb_pkg::ASID_W){1'b0}}, rd_entry.tag.asid};
				entry_lo_even_out <= smtlb_pkg::unpack_page(rd_entry.even, rd_entry.tag.g);
				entry_lo_odd_out  <= smtlb_pkg::unpack_page(rd_entry.odd, rd_entry.tag.g);
				page_mask_out     <= rd_entry.mask;
			end
		end
	end

	assign out_valid = out_valid_q;

	// A new result is loaded only when the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a word still waiting");

	// The store is never written while it is being read.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && rd_en))
		else $error("store written and read in the same cycle");

	// A word only appears after the controller finished an instruction.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output word appeared without a finished instruction");

	// A probe ends by the time the last slot has been checked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.probe_step && chk_vld_s1 && chk_slot_s1 == IW'(ENTRY_COUNT - 1))
		|-> sts.probe_done)
		else $error("probe ran past the last slot");

endmodule

// ===== hw/rtl/software_managed_tlb_unit.sv =====
// Top level of the software-managed TLB unit: controller plus datapath.
// The unit executes one TLB instruction at a time from a word on the input
// channel and holds ENTRY_COUNT entries, all reading as zero straight after
// reset (per-slot written flags are cleared at once, so there is no clearing
// pass). Writes by Index or Random and reads first reduce the 32-bit Index
// word (for a random write, the random_slot value) modulo ENTRY_COUNT one hex
// digit per cycle; a probe scans the store one slot per cycle through its
// single read port and stops at the first match or after the last slot. A
// read or probe then waits for the output register to be free. Writes produce
// no output word; probes and reads produce exactly one, and a result waiting
// in the output register does not block the next instruction.
module software_managed_tlb_unit #(
	parameter int ENTRY_COUNT = smtlb_pkg::ENTRY_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] entry_hi,
	input  logic [31:0] entry_lo_even,
	input  logic [31:0] entry_lo_odd,
	input  logic [31:0] page_mask_in,
	input  logic [31:0] index_in,
	input  logic [3:0]  random_slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] index_out,
	output logic        probe_miss,
	output logic [31:0] entry_hi_out,
	output logic [31:0] entry_lo_even_out,
	output logic [31:0] entry_lo_odd_out,
	output logic [31:0] page_mask_out
);

	smtlb_pkg::cmd_t    cmd;
	smtlb_pkg::status_t sts;

	// Instruction sequencing.
	smtlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Entry store and result datapath.
	smtlb_dp #(
		.ENTRY_COUNT (ENTRY_COUNT)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.opcode            (opcode),
		.entry_hi          (entry_hi),
		.entry_lo_even     (entry_lo_even),
		.entry_lo_odd      (entry_lo_odd),
		.page_mask_in      (page_mask_in),
		.index_in          (index_in),
		.random_slot       (random_slot),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.index_out         (index_out),
		.probe_miss        (probe_miss),
		.entry_hi_out      (entry_hi_out),
		.entry_lo_even_out (entry_lo_even_out),
		.entry_lo_odd_out  (entry_lo_odd_out),
		.page_mask_out     (page_mask_out)
	);

endmodule

// ===== verif/software_managed_tlb_unit_tb.sv =====
// Self-checking testbench for the software-managed TLB unit.
module software_managed_tlb_unit_tb;

	localparam int unsigned ENTRIES = smtlb_pkg::ENTRY_COUNT_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int RANDOM_WORDS = 600;

	// One TLB instruction as offered on the input channel.
	typedef struct {
		smtlb_pkg::op_t op;
		logic [31:0]    hi;
		logic [31:0]    lo0;
		logic [31:0]    lo1;
		logic [31:0]    pm;
		logic [31:0]    idx;
		logic [3:0]     rnd;
	} tlb_cmd_t;

	// One word on the output channel.
	typedef struct {
		logic [31:0] index;
		logic        miss;
		logic [31:0] hi;
		logic [31:0] lo0;
		logic [31:0] lo1;
		logic [31:0] pm;
	} tlb_result_t;

	// Shadow copy of the TLB store and the queue of results it predicts.
	class tlb_scoreboard_t;
		smtlb_pkg::tag_t  tags [ENTRIES];
		logic [31:0]      masks [ENTRIES];
		smtlb_pkg::page_t even_pg [ENTRIES];
		smtlb_pkg::page_t odd_pg [ENTRIES];
		tlb_result_t      expected_q [$];
		int               errors;
		int               checked;
		int               writes;
		int               reads;
		int               hits;
		int               misses;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				tags[i] = '0;
				masks[i] = '0;
				even_pg[i] = '0;
				odd_pg[i] = '0;
			end
			errors = 0;
			checked = 0;
			writes = 0;
			reads = 0;
			hits = 0;
			misses = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// EntryLo layout: G bit 0, V bit 1, D bit 2, C bits 5:3, PFN bits 31:6.
		function smtlb_pkg::page_t half_of(logic [31:0] lo);
			smtlb_pkg::page_t p;
			p.v = lo[1];
			p.d = lo[2];
			p.c = lo[5:3];
			p.pfn = lo[31:6];
			return p;
		endfunction

		// Apply one accepted instruction to the shadow store and queue its result.
		function void note_word(tlb_cmd_t c);
			int unsigned     slot;
			bit              hit;
			tlb_result_t     r;
			smtlb_pkg::tag_t t;
			r = '{default: '0};
			hit = 0;
			slot = 0;
			unique case (c.op)
				smtlb_pkg::OP_WRITE_INDEXED, smtlb_pkg::OP_WRITE_RANDOM: begin
					slot = (c.op == smtlb_pkg::OP_WRITE_INDEXED) ? c.idx % ENTRIES
						: c.rnd % ENTRIES;
					tags[slot].vpn2 = c.hi[31:13];
					tags[slot].asid = c.hi[7:0];
					tags[slot].g = c.lo0[0] & c.lo1[0];
					masks[slot] = c.pm;
					even_pg[slot] = half_of(c.lo0);
					odd_pg[slot] = half_of(c.lo1);
					writes++;
				end
				smtlb_pkg::OP_PROBE: begin
					// The lowest matching slot wins; a global entry ignores the ASID.
					for (int i = 0; i < ENTRIES; i++) begin
						if (!hit && (tags[i].g || tags[i].asid == c.hi[7:0]) &&
								tags[i].vpn2 == c.hi[31:13]) begin
							hit = 1;
							slot = i;
						end
					end
					r.index = hit ? slot : (c.idx | smtlb_pkg::MISS_BIT);
					r.miss = !hit;
					if (hit)
						hits++;
					else
						misses++;
					expected_q.push_back(r);
				end
				default: begin
					slot = c.idx % ENTRIES;
					t = tags[slot];
					r.hi = {t.vpn2, 5'b0, t.asid};
					r.lo0 = {even_pg[slot].pfn, even_pg[slot].c, even_pg[slot].d,
						even_pg[slot].v, t.g};
					r.lo1 = {odd_pg[slot].pfn, odd_pg[slot].c, odd_pg[slot].d,
						odd_pg[slot].v, t.g};
					r.pm = masks[slot];
					reads++;
					expected_q.push_back(r);
				end
			endcase
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
			if (got_v !== exp_v) begin
				$error("%s: expected %h, actual %h", name, exp_v, got_v);
				errors++;
			end
		endfunction

		// Compare one accepted output word with the oldest prediction.
		function void check_word(tlb_result_t got);
			tlb_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("output word with no prediction waiting: index_out %h", got.index);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			compare_field("index_out", exp_r.index, got.index);
			compare_field("probe_miss", {31'b0, exp_r.miss}, {31'b0, got.miss});
			compare_field("entry_hi_out", exp_r.hi, got.hi);
			compare_field("entry_lo_even_out", exp_r.lo0, got.lo0);
			compare_field("entry_lo_odd_out", exp_r.lo1, got.lo1);
			compare_field("page_mask_out", exp_r.pm, got.pm);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  opcode;
	logic [31:0] entry_hi;
	logic [31:0] entry_lo_even;
	logic [31:0] entry_lo_odd;
	logic [31:0] page_mask_in;
	logic [31:0] index_in;
	logic [3:0]  random_slot;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] index_out;
	logic        probe_miss;
	logic [31:0] entry_hi_out;
	logic [31:0] entry_lo_even_out;
	logic [31:0] entry_lo_odd_out;
	logic [31:0] page_mask_out;

	tlb_scoreboard_t sb;
	bit              idle_on = 1'b1;
	bit              hold_req = 1'b0;
	logic [18:0]     vpn_pool [6] = '{19'h00000, 19'h7FFFF, 19'h00001, 19'h2AAAA, 19'h15555,
		19'h00C3F};
	logic [7:0]      asid_pool [4] = '{8'h00, 8'hFF, 8'h5A, 8'h01};

	software_managed_tlb_unit #(
		.ENTRY_COUNT(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.entry_hi(entry_hi),
		.entry_lo_even(entry_lo_even),
		.entry_lo_odd(entry_lo_odd),
		.page_mask_in(page_mask_in),
		.index_in(index_in),
		.random_slot(random_slot),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.index_out(index_out),
		.probe_miss(probe_miss),
		.entry_hi_out(entry_hi_out),
		.entry_lo_even_out(entry_lo_even_out),
		.entry_lo_odd_out(entry_lo_odd_out),
		.page_mask_out(page_mask_out)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 32);
			end
		end
	end

	// Output monitor: every accepted result word goes to the scoreboard.
	always @(posedge clk) begin : result_monitor
		tlb_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.index = index_out;
			got.miss = probe_miss;
			got.hi = entry_hi_out;
			got.lo0 = entry_lo_even_out;
			got.lo1 = entry_lo_odd_out;
			got.pm = page_mask_out;
			sb.check_word(got);
		end
	end

	// Overall time limit.
	initial begin
		#(TIMEOUT_CYCLES * 8);
		$display("FAIL");
		$finish;
	end

	function automatic tlb_cmd_t mk(smtlb_pkg::op_t op, logic [31:0] hi, logic [31:0] lo0,
			logic [31:0] lo1, logic [31:0] pm, logic [31:0] idx, logic [3:0] rnd);
		tlb_cmd_t c;
		c.op = op;
		c.hi = hi;
		c.lo0 = lo0;
		c.lo1 = lo1;
		c.pm = pm;
		c.idx = idx;
		c.rnd = rnd;
		return c;
	endfunction

	// Random instruction; most tags come from a small pool so that probes hit.
	function automatic tlb_cmd_t random_cmd();
		tlb_cmd_t c;
		int       sel;
		sel = $urandom_range(99);
		if (sel < 22)
			c.op = smtlb_pkg::OP_WRITE_INDEXED;
		else if (sel < 40)
			c.op = smtlb_pkg::OP_WRITE_RANDOM;
		else if (sel < 72)
			c.op = smtlb_pkg::OP_PROBE;
		else
			c.op = smtlb_pkg::OP_READ;
		c.hi = $urandom;
		if ($urandom_range(99) < 75) begin
			c.hi[31:13] = vpn_pool[$urandom_range(5)];
			c.hi[7:0] = asid_pool[$urandom_range(3)];
		end
		c.lo0 = $urandom;
		c.lo1 = $urandom;
		c.pm = $urandom;
		c.idx = ($urandom_range(99) < 30) ? $urandom_range(15) : $urandom;
		c.rnd = $urandom_range(15);
		return c;
	endfunction

	// Offer one word, with random idle cycles first, and wait for its acceptance.
	task automatic send_word(tlb_cmd_t c);
		while (idle_on && $urandom_range(99) < 32) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= c.op;
		entry_hi <= c.hi;
		entry_lo_even <= c.lo0;
		entry_lo_odd <= c.lo1;
		page_mask_in <= c.pm;
		index_in <= c.idx;
		random_slot <= c.rnd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(c);
	endtask

	// Stop offering and wait until every predicted result has come.
	task automatic wait_drained();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending() != 0) begin
			$error("%0d predicted results never arrived", sb.pending());
			sb.errors++;
		end
		repeat (20) @(posedge clk);
	endtask

	// Main sequence.
	initial begin
		tlb_cmd_t directed [$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = smtlb_pkg::OP_WRITE_INDEXED;
		entry_hi = '0;
		entry_lo_even = '0;
		entry_lo_odd = '0;
		page_mask_in = '0;
		index_in = '0;
		random_slot = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fresh store reads as zero, and an unwritten entry matches VPN2 0, ASID 0.
		directed.push_back(mk(smtlb_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h1234_5678, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, '1, 32'h0, 32'h0, 32'h0,
			32'h7FFF_FFFF, 4'h0));
		// All-ones entry written through an out-of-range index, read back and probed.
		directed.push_back(mk(smtlb_pkg::OP_WRITE_INDEXED, '1, '1, '1, '1,
			32'hFFFF_FFF3, 4'hF));
		directed.push_back(mk(smtlb_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0000_0013, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, 32'hFFFF_E0FF, 32'h0, 32'h0, 32'h0,
			32'h0, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, 32'hFFFF_E000, 32'h0, 32'h0, 32'h0,
			32'h0, 4'h0));
		// Non-global entry at the top random slot: the ASID must match.
		directed.push_back(mk(smtlb_pkg::OP_WRITE_RANDOM, 32'h0000_2005, 32'h1, 32'h0,
			32'h001F_E000, 32'h0, 4'hF));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, 32'h0000_2006, 32'h0, 32'h0, 32'h0,
			32'h8000_0000, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, 32'h0000_2005, 32'h0, 32'h0, 32'h0,
			32'h0, 4'h0));
		// Two entries with the same tag: the lower slot must win.
		directed.push_back(mk(smtlb_pkg::OP_WRITE_INDEXED, 32'h0005_4033, 32'hAAAA_AAAA,
			32'h5555_5555, 32'h0000_6000, 32'h9, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_WRITE_INDEXED, 32'h0005_4033, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h0, 32'h5, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, 32'h0005_4033, 32'h0, 32'h0, 32'h0,
			32'h0, 4'h0));
		// A read ignores EntryHi.
		directed.push_back(mk(smtlb_pkg::OP_READ, 32'hDEAD_BEEF, 32'h0, 32'h0, 32'h0,
			32'h9, 4'h0));
		// Slot zero overwritten with zeros through the random path, then by index.
		directed.push_back(mk(smtlb_pkg::OP_WRITE_RANDOM, 32'h0, 32'h0, 32'h0, 32'h0,
			32'hFFFF_FFFF, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_WRITE_INDEXED, 32'h0000_1F00, 32'h0000_003E,
			32'h0000_0001, 32'h0, 32'h10, 4'h3));
		directed.push_back(mk(smtlb_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, 32'hF, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_PROBE, 32'h0000_1F00, 32'h0, 32'h0, 32'h0,
			32'h0, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, '1, 4'h0));
		directed.push_back(mk(smtlb_pkg::OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0));
		foreach (directed[i])
			send_word(directed[i]);
		wait_drained();

		// Random part: a long receiver hold-off, a full drain, and a stretch without idling.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 100)
				hold_req = 1'b1;
			if (n == 300)
				wait_drained();
			if (n == 350)
				idle_on = 1'b0;
			if (n == 450)
				idle_on = 1'b1;
			send_word(random_cmd());
		end
		wait_drained();

		$display("Covered %0d writes, %0d reads and %0d probes (%0d hits, %0d misses).",
			sb.writes, sb.reads, sb.hits + sb.misses, sb.hits, sb.misses);
		$display("Checked %0d result words with %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== software_managed_tlb_unit.f =====
hw/rtl/smtlb_pkg.sv
hw/rtl/smtlb_ram.sv
hw/rtl/smtlb_ctrl.sv
hw/rtl/smtlb_dp.sv
hw/rtl/software_managed_tlb_unit.sv
verif/software_managed_tlb_unit_tb.sv
